[rtl/record_stream_validator_defines.svh]
// Assertion macros shared by the record stream validator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RECORD_STREAM_VALIDATOR_DEFINES_SVH
`define RECORD_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define RSV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rsv_pkg.sv]
// Shared types, codes and constants of the record stream validator.
// No dependencies; imported by every rtl module.
package rsv_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int NUM_SPECIES     = 5;
  localparam int ADDR_BITS       = 5;

  localparam logic [6:0] HDR_BYTES        = 7'd16;
  localparam logic [6:0] MAX_RECORD_BYTES = 7'd124;

  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_VERSION   = 3'd3;
  localparam logic [2:0] ST_SPECIES   = 3'd4;
  localparam logic [2:0] ST_SIZE      = 3'd5;
  localparam logic [2:0] ST_SHORT_REC = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  localparam logic [1:0] WORD_MAGIC   = 2'd0;
  localparam logic [1:0] WORD_VERSION = 2'd1;
  localparam logic [1:0] WORD_SIZE    = 2'd2;
  localparam logic [1:0] WORD_SPECIES = 2'd3;

  localparam logic [2:0] REG_MAGIC      = 3'd0;
  localparam logic [2:0] REG_VERSION    = 3'd1;
  localparam logic [2:0] REG_DARK       = 3'd2;
  localparam logic [2:0] REG_GAS        = 3'd3;
  localparam logic [2:0] REG_STAR       = 3'd4;
  localparam logic [2:0] REG_BLACK_HOLE = 3'd5;
  localparam logic [2:0] REG_TRACER     = 3'd6;

  typedef struct packed {
    logic [31:0]                  magic;
    logic [31:0]                  version;
    logic [NUM_SPECIES-1:0][31:0] code;
  } cfg_t;

  function automatic logic [6:0] species_bytes(input logic [2:0] idx);
    logic [6:0] n;
    case (idx)
      3'd0:    n = 7'd80;
      3'd1:    n = 7'd104;
      3'd2:    n = 7'd104;
      3'd3:    n = 7'd96;
      3'd4:    n = 7'd124;
      default: n = 7'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/rsv_cfg.sv]
// APB register file: magic, version and the five species tags.
// Depends on rsv_pkg.
module rsv_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsv_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rsv_pkg::cfg_t                 cfg
);
  import rsv_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_MAGIC:      cfg_nxt.magic   = pwdata;
        REG_VERSION:    cfg_nxt.version = pwdata;
        REG_DARK:       cfg_nxt.code[0] = pwdata;
        REG_GAS:        cfg_nxt.code[1] = pwdata;
        REG_STAR:       cfg_nxt.code[2] = pwdata;
        REG_BLACK_HOLE: cfg_nxt.code[3] = pwdata;
        REG_TRACER:     cfg_nxt.code[4] = pwdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAGIC:      prdata = cfg_r.magic;
      REG_VERSION:    prdata = cfg_r.version;
      REG_DARK:       prdata = cfg_r.code[0];
      REG_GAS:        prdata = cfg_r.code[1];
      REG_STAR:       prdata = cfg_r.code[2];
      REG_BLACK_HOLE: prdata = cfg_r.code[3];
      REG_TRACER:     prdata = cfg_r.code[4];
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic   <= 32'd0;
      cfg_r.version <= 32'd2;
      cfg_r.code[0] <= 32'd0;
      cfg_r.code[1] <= 32'd1;
      cfg_r.code[2] <= 32'd2;
      cfg_r.code[3] <= 32'd3;
      cfg_r.code[4] <= 32'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/rsv_front.sv]
// Input side: takes words, tags each with its buffer offset, marks end items.
// Depends on rsv_pkg; feeds rsv_queue.
module rsv_front #(
  parameter int OFFSET_BITS = rsv_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_action,
  input  logic [7:0]             in_data_byte,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [OFFSET_BITS+8:0] q_wdata
);
  import rsv_pkg::*;

  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_wdata  = {in_action, in_data_byte, offset_r};

  // position wraps at 2^OFFSET_BITS; an end item starts a new buffer
  always_comb begin
    offset_nxt = offset_r;
    if (q_push) begin
      if (in_action) offset_nxt = '0;
      else           offset_nxt = offset_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else begin
      offset_r <= offset_nxt;
    end
  end

endmodule

[rtl/rsv_queue.sv]
// Short FIFO between the front and back ends.
// Depends on rsv_pkg for the default depth.
module rsv_queue #(
  parameter int WIDTH = 41,
  parameter int DEPTH = rsv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  import rsv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/rsv_back.sv]
// Back end: header assembly and checks, record framing, results and summary.
// Depends on rsv_pkg and record_stream_validator_defines.svh; fed by rsv_queue.
`include "record_stream_validator_defines.svh"

module rsv_back #(
  parameter int OFFSET_BITS = rsv_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = rsv_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rsv_pkg::cfg_t          cfg,
  input  logic                   q_valid,
  input  logic [OFFSET_BITS+8:0] q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [2:0]             out_status,
  output logic [2:0]             out_species_index,
  output logic [31:0]            out_record_begin,
  output logic [6:0]             out_record_size,
  output logic [31:0]            out_record_count
);
  import rsv_pkg::*;

  logic                   it_end;
  logic [7:0]             it_byte;
  logic [OFFSET_BITS-1:0] it_off;
  logic                   take;

  logic [6:0]             p_r, p_nxt;
  logic [31:0]            word_r, word_nxt;
  logic [31:0]            decl_r, decl_nxt;
  logic [2:0]             pend_r, pend_nxt;
  logic [2:0]             spec_r, spec_nxt;
  logic [6:0]             exp_r, exp_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [OFFSET_BITS-1:0] rbeg_r, rbeg_nxt;
  logic [OFFSET_BITS-1:0] lbeg_r, lbeg_nxt;
  logic [6:0]             lsize_r, lsize_nxt;
  logic [2:0]             latch_r, latch_nxt;

  logic                   ov_r, ov_nxt;
  logic [1:0]             okind_r, okind_nxt;
  logic [2:0]             ostat_r, ostat_nxt;
  logic [2:0]             ospec_r, ospec_nxt;
  logic [31:0]            obeg_r, obeg_nxt;
  logic [6:0]             osize_r, osize_nxt;
  logic [31:0]            ocnt_r, ocnt_nxt;

  logic [31:0]            w;
  logic [2:0]             pend_cur, spec_cur;
  logic [6:0]             exp_cur;
  logic                   found;
  logic [2:0]             found_spec;
  logic [6:0]             found_exp;
  logic [2:0]             end_st;

  assign it_end  = q_rdata[OFFSET_BITS+8];
  assign it_byte = q_rdata[OFFSET_BITS+7:OFFSET_BITS];
  assign it_off  = q_rdata[OFFSET_BITS-1:0];
  assign take    = q_valid && (!ov_r || !out_stall);
  assign q_pop   = take;

  assign w        = {it_byte, word_r[31:8]};
  assign pend_cur = (p_r == 7'd0) ? ST_OK : pend_r;
  assign spec_cur = (p_r == 7'd0) ? 3'd0 : spec_r;
  assign exp_cur  = (p_r == 7'd0) ? 7'd0 : exp_r;

  // first matching tag wins
  always_comb begin
    found      = 1'b0;
    found_spec = 3'd0;
    found_exp  = 7'd0;
    for (int k = 0; k < NUM_SPECIES; k++) begin
      if (!found && w == cfg.code[k]) begin
        found      = 1'b1;
        found_spec = 3'(k);
        found_exp  = species_bytes(3'(k));
      end
    end
  end

  always_comb begin
    if (latch_r != ST_OK)        end_st = latch_r;
    else if (p_r >= HDR_BYTES)   end_st = ST_SHORT_REC;
    else if (p_r != 7'd0)        end_st = ST_SHORT_HDR;
    else                         end_st = ST_OK;
  end

  always_comb begin
    p_nxt     = p_r;
    word_nxt  = word_r;
    decl_nxt  = decl_r;
    pend_nxt  = pend_r;
    spec_nxt  = spec_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    rbeg_nxt  = rbeg_r;
    lbeg_nxt  = lbeg_r;
    lsize_nxt = lsize_r;
    latch_nxt = latch_r;

    ov_nxt    = ov_r && out_stall;
    okind_nxt = okind_r;
    ostat_nxt = ostat_r;
    ospec_nxt = ospec_r;
    obeg_nxt  = obeg_r;
    osize_nxt = osize_r;
    ocnt_nxt  = ocnt_r;

    if (take) begin
      ov_nxt = 1'b0;
      if (it_end) begin
        ov_nxt    = 1'b1;
        okind_nxt = KIND_SUMMARY;
        ostat_nxt = end_st;
        ospec_nxt = 3'd0;
        obeg_nxt  = (lsize_r == 7'd0) ? 32'(it_off) : 32'(lbeg_r);
        osize_nxt = lsize_r;
        ocnt_nxt  = 32'(cnt_r);
        p_nxt     = 7'd0;
        word_nxt  = 32'd0;
        decl_nxt  = 32'd0;
        pend_nxt  = ST_OK;
        spec_nxt  = 3'd0;
        exp_nxt   = 7'd0;
        cnt_nxt   = '0;
        rbeg_nxt  = '0;
        lbeg_nxt  = '0;
        lsize_nxt = 7'd0;
        latch_nxt = ST_OK;
      end else if (latch_r == ST_OK) begin
        if (p_r < HDR_BYTES) begin
          word_nxt = w;
          pend_nxt = pend_cur;
          spec_nxt = spec_cur;
          exp_nxt  = exp_cur;
          if (p_r == 7'd0) rbeg_nxt = it_off;
          if (p_r[1:0] == 2'd3) begin
            unique case (p_r[3:2])
              WORD_MAGIC: begin
                if (pend_cur == ST_OK && w != cfg.magic) pend_nxt = ST_MAGIC;
              end
              WORD_VERSION: begin
                if (pend_cur == ST_OK && w != cfg.version) pend_nxt = ST_VERSION;
              end
              WORD_SIZE: begin
                decl_nxt = w;
              end
              WORD_SPECIES: begin
                spec_nxt = found_spec;
                exp_nxt  = found_exp;
                if (pend_cur == ST_OK) begin
                  if (!found)                        pend_nxt = ST_SPECIES;
                  else if (decl_r != 32'(found_exp)) pend_nxt = ST_SIZE;
                end
              end
              default: decl_nxt = decl_r;
            endcase
          end
          if (p_r == HDR_BYTES - 7'd1 && pend_nxt != ST_OK) begin
            latch_nxt = pend_nxt;
            ov_nxt    = 1'b1;
            okind_nxt = KIND_ERROR;
            ostat_nxt = pend_nxt;
            ospec_nxt = spec_nxt;
            obeg_nxt  = 32'(rbeg_r);
            osize_nxt = exp_nxt;
            ocnt_nxt  = 32'(cnt_r);
          end else begin
            p_nxt = p_r + 7'd1;
          end
        end else if ({1'b0, p_r} + 8'd1 >= {1'b0, exp_r}) begin
          p_nxt     = 7'd0;
          ov_nxt    = 1'b1;
          ospec_nxt = spec_r;
          obeg_nxt  = 32'(rbeg_r);
          osize_nxt = exp_r;
          if (cnt_r == '1) begin
            latch_nxt = ST_OVERFLOW;
            okind_nxt = KIND_ERROR;
            ostat_nxt = ST_OVERFLOW;
            ocnt_nxt  = 32'(cnt_r);
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            lbeg_nxt  = rbeg_r;
            lsize_nxt = exp_r;
            okind_nxt = KIND_RECORD;
            ostat_nxt = ST_OK;
            ocnt_nxt  = 32'(cnt_r + 1'b1);
          end
        end else begin
          p_nxt = p_r + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r     <= 7'd0;
      word_r  <= 32'd0;
      decl_r  <= 32'd0;
      pend_r  <= ST_OK;
      spec_r  <= 3'd0;
      exp_r   <= 7'd0;
      cnt_r   <= '0;
      rbeg_r  <= '0;
      lbeg_r  <= '0;
      lsize_r <= 7'd0;
      latch_r <= ST_OK;
      ov_r    <= 1'b0;
    end else begin
      p_r     <= p_nxt;
      word_r  <= word_nxt;
      decl_r  <= decl_nxt;
      pend_r  <= pend_nxt;
      spec_r  <= spec_nxt;
      exp_r   <= exp_nxt;
      cnt_r   <= cnt_nxt;
      rbeg_r  <= rbeg_nxt;
      lbeg_r  <= lbeg_nxt;
      lsize_r <= lsize_nxt;
      latch_r <= latch_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    ostat_r <= ostat_nxt;
    ospec_r <= ospec_nxt;
    obeg_r  <= obeg_nxt;
    osize_r <= osize_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign out_valid         = ov_r;
  assign out_kind          = okind_r;
  assign out_status        = ostat_r;
  assign out_species_index = ospec_r;
  assign out_record_begin  = obeg_r;
  assign out_record_size   = osize_r;
  assign out_record_count  = ocnt_r;

  `RSV_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1, p_r < MAX_RECORD_BYTES, "record position out of range")
  `RSV_ASSERT_NOW(a_body_size, clk, rst_n, p_r >= HDR_BYTES, exp_r != 7'd0 && latch_r == ST_OK, "record body without a species size")
  `RSV_ASSERT_NEXT(a_quiet_after_err, clk, rst_n, take && !it_end && latch_r != ST_OK, !ov_r, "word after an error produced a result")
  `RSV_ASSERT_NEXT(a_end_clears, clk, rst_n, take && it_end, p_r == 7'd0 && cnt_r == '0 && latch_r == ST_OK && ov_r, "end word did not clear the stream")

endmodule

[rtl/record_stream_validator.sv]
// Top level of the record stream validator: config regs, front end, queue, back end.
// Depends on rsv_pkg, rsv_cfg, rsv_front, rsv_queue and rsv_back.
//
// Checks a byte stream of framed particle records, one byte per word on the in_ channel,
// closed by an end word (in_action = 1). Each record opens with a 16-byte little-endian
// header (magic, version, byte count, species tag) that is checked against the APB
// registers once the header is complete. One result word comes out per accepted record,
// for the first error, and as a summary for each end word; after an error, bytes are
// dropped until the end word. Throughput is one word per cycle sustained while out_stall
// is low. out_valid rises once its word has been written into the input queue and the
// back end has checked it and registered the result. A two-word queue between front and
// back end absorbs out_stall, so in_stall rises only while that queue is full.
module record_stream_validator #(
  parameter int OFFSET_BITS = rsv_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = rsv_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsv_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [2:0]                    out_status,
  output logic [2:0]                    out_species_index,
  output logic [31:0]                   out_record_begin,
  output logic [6:0]                    out_record_size,
  output logic [31:0]                   out_record_count
);
  import rsv_pkg::*;

  localparam int EW = OFFSET_BITS + 9;

  cfg_t          cfg;
  logic          q_full, q_push, q_pop, q_valid;
  logic [EW-1:0] q_wdata, q_rdata;

  rsv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsv_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  rsv_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  rsv_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_species_index (out_species_index),
    .out_record_begin  (out_record_begin),
    .out_record_size   (out_record_size),
    .out_record_count  (out_record_count)
  );

endmodule
